>>> rtl/core/vpdt_pkg.sv
// Shared types, constants and codes of the vote packet dedup and tally block.
`timescale 1ns / 1ps
`default_nettype none
package vpdt_pkg;

	localparam int SEEN_DEPTH   = 1024;
	localparam int VOTER_DEPTH  = 1024;
	localparam int OPTION_COUNT = 5;
	localparam int SEEN_AW      = $clog2(SEEN_DEPTH);
	localparam int VOTER_AW     = $clog2(VOTER_DEPTH);
	localparam int FILL_W       = 11;
	localparam int OPT_W        = 3;
	localparam int ID_W         = 32;
	localparam int SEQ_W        = 8;
	localparam int PCT_W        = 7;
	localparam int DIVD_W       = 17;

	localparam logic [7:0] CODE_LOW  = 8'h81;
	localparam logic [7:0] HEAD_ZERO = 8'h02;
	localparam logic [7:0] HEAD_ONE  = 8'h13;
	localparam logic [6:0] PCT_FULL  = 7'd100;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_REPORT = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] ST_NEW    = 3'd0;
	localparam logic [2:0] ST_DUP    = 3'd1;
	localparam logic [2:0] ST_IGNORE = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_REPORT = 3'd4;

	typedef enum logic [1:0] {
		KIND_RECORD,
		KIND_BAD,
		KIND_REPORT,
		KIND_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   id;
		logic [OPT_W-1:0]  opt;
		logic [SEQ_W-1:0]  seq;
	} req_t;

	typedef struct packed {
		logic pop;
		logic seen_re;
		logic voter_re;
		logic emit;
	} back_ctl_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SEEN_RD,
		BK_SEEN_CMP,
		BK_VOT_RD,
		BK_VOT_CMP,
		BK_COMMIT,
		BK_DIV_LOAD,
		BK_DIV,
		BK_ROUND,
		BK_EMIT
	} back_state_t;

endpackage
`default_nettype wire

>>> rtl/core/vpdt_front.sv
// Front end: accepts input requests, checks records and decodes remote ID and option.
`timescale 1ns / 1ps
`default_nettype none
module vpdt_front (
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [55:0]    s_tdata,
	input  wire logic [1:0]     s_tuser,
	input  wire logic           q_full,
	output logic                push,
	output vpdt_pkg::req_t      req
);

	logic [7:0] head_first, head_second, answer_code, id_high, id_mid, id_low, seq_b;
	logic       rec_ok;

	assign head_first  = s_tdata[7:0];
	assign head_second = s_tdata[15:8];
	assign answer_code = s_tdata[23:16];
	assign id_high     = s_tdata[31:24];
	assign id_mid      = s_tdata[39:32];
	assign id_low      = s_tdata[47:40];
	assign seq_b       = s_tdata[55:48];

	assign rec_ok = (answer_code >= vpdt_pkg::CODE_LOW) &&
		(answer_code < vpdt_pkg::CODE_LOW + 8'(vpdt_pkg::OPTION_COUNT)) &&
		(head_first == vpdt_pkg::HEAD_ZERO) && (head_second == vpdt_pkg::HEAD_ONE);

	assign s_tready = !q_full;

	always_comb begin
		req.id   = '0;
		req.opt  = '0;
		req.seq  = seq_b;
		req.kind = vpdt_pkg::KIND_BAD;
		push     = s_tvalid && s_tready;
		case (s_tuser)
			vpdt_pkg::CMD_RECORD: begin
				if (rec_ok) begin
					req.kind = vpdt_pkg::KIND_RECORD;
					req.id   = {id_high, id_mid, id_low, id_high ^ id_mid ^ id_low};
					req.opt  = vpdt_pkg::OPT_W'(answer_code - vpdt_pkg::CODE_LOW);
				end
			end
			vpdt_pkg::CMD_REPORT: req.kind = vpdt_pkg::KIND_REPORT;
			vpdt_pkg::CMD_CLEAR:  req.kind = vpdt_pkg::KIND_CLEAR;
			default:              push = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/vpdt_queue.sv
// Two-entry queue of decoded requests between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module vpdt_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire vpdt_pkg::req_t push_req,
	input  wire logic           pop,
	output vpdt_pkg::req_t      head,
	output logic                full,
	output logic                empty
);

	vpdt_pkg::req_t ent_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;

	assign full  = cnt_q[1];
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/vpdt_back.sv
// Back end: table searches, vote update, percentage report and the result register.
`timescale 1ns / 1ps
`default_nettype none
module vpdt_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire vpdt_pkg::req_t head,
	input  wire logic           q_empty,
	output logic                pop,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [87:0]         m_tdata,
	output logic [2:0]          m_tuser
);

	localparam int SEEN_W  = vpdt_pkg::ID_W + vpdt_pkg::OPT_W + vpdt_pkg::SEQ_W;
	localparam int VOTER_W = vpdt_pkg::ID_W + vpdt_pkg::OPT_W;
	localparam int NOPT    = vpdt_pkg::OPTION_COUNT;
	localparam int FW      = vpdt_pkg::FILL_W;

	vpdt_pkg::back_state_t state_q, state_nx;
	vpdt_pkg::back_ctl_t   ctl;
	vpdt_pkg::req_t        req_q;

	logic [SEEN_W-1:0]  seen_mem [vpdt_pkg::SEEN_DEPTH];
	logic [VOTER_W-1:0] voter_mem [vpdt_pkg::VOTER_DEPTH];
	logic [SEEN_W-1:0]  seen_rd_q;
	logic [VOTER_W-1:0] voter_rd_q;

	logic [FW-1:0] seen_fill_q, voter_fill_q, k_q;
	logic [FW-1:0] cnt_q [NOPT];
	logic [FW-1:0] rem_q [NOPT];
	logic [vpdt_pkg::PCT_W-1:0] pct_q [NOPT];
	logic [NOPT-1:0] bumped_q;
	logic [vpdt_pkg::PCT_W-1:0] sum_q;
	logic [2:0] status_q;
	logic found_q;
	logic [vpdt_pkg::OPT_W-1:0] old_opt_q, idx_q;
	logic [vpdt_pkg::VOTER_AW-1:0] vi_q;

	logic [vpdt_pkg::DIVD_W-1:0] divd_q;
	logic [FW-1:0] drem_q;
	logic [4:0] bit_q;
	logic [FW:0] rem_try;
	logic rem_ge;
	logic [FW-1:0] rem_nx;
	logic [vpdt_pkg::DIVD_W-1:0] divd_nx;
	logic [FW-1:0] cnt_sel;

	logic [FW-1:0] k_inc;
	logic seen_hit, voter_hit, seen_last, voter_last, full_hit;
	logic best_found;
	logic [vpdt_pkg::OPT_W-1:0] best_idx;
	logic [FW-1:0] best_rem;

	assign pop       = ctl.pop;
	assign k_inc     = k_q + FW'(1);
	assign seen_last = (k_inc == seen_fill_q);
	assign voter_last = (k_inc == voter_fill_q);
	assign seen_hit  = (seen_rd_q == {req_q.seq, req_q.opt, req_q.id});
	assign voter_hit = (voter_rd_q[vpdt_pkg::ID_W-1:0] == req_q.id);
	assign full_hit  = (seen_fill_q == FW'(vpdt_pkg::SEEN_DEPTH)) ||
		(!found_q && voter_fill_q == FW'(vpdt_pkg::VOTER_DEPTH));

	assign rem_try = {drem_q, divd_q[vpdt_pkg::DIVD_W-1]};
	assign rem_ge  = (rem_try >= {1'b0, voter_fill_q});
	assign rem_nx  = rem_ge ? FW'(rem_try - {1'b0, voter_fill_q}) : FW'(rem_try);
	assign divd_nx = {divd_q[vpdt_pkg::DIVD_W-2:0], rem_ge};

	always_comb begin
		cnt_sel = '0;
		for (int i = 0; i < NOPT; i++) begin
			if (idx_q == vpdt_pkg::OPT_W'(i)) begin
				cnt_sel = cnt_q[i];
			end
		end
	end

	always_comb begin
		best_found = 1'b0;
		best_idx   = '0;
		best_rem   = '0;
		for (int i = 0; i < NOPT; i++) begin
			if (!bumped_q[i] && rem_q[i] != '0 && (!best_found || rem_q[i] > best_rem)) begin
				best_found = 1'b1;
				best_idx   = vpdt_pkg::OPT_W'(i);
				best_rem   = rem_q[i];
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			vpdt_pkg::BK_IDLE: begin
				if (!q_empty) begin
					case (head.kind)
						vpdt_pkg::KIND_RECORD: state_nx = (seen_fill_q == '0) ?
							((voter_fill_q == '0) ? vpdt_pkg::BK_COMMIT : vpdt_pkg::BK_VOT_RD) :
							vpdt_pkg::BK_SEEN_RD;
						vpdt_pkg::KIND_BAD:    state_nx = vpdt_pkg::BK_EMIT;
						vpdt_pkg::KIND_REPORT: state_nx = (voter_fill_q == '0) ?
							vpdt_pkg::BK_EMIT : vpdt_pkg::BK_DIV_LOAD;
						default:               state_nx = vpdt_pkg::BK_IDLE;
					endcase
				end
			end
			vpdt_pkg::BK_SEEN_RD:  state_nx = vpdt_pkg::BK_SEEN_CMP;
			vpdt_pkg::BK_SEEN_CMP: begin
				if (seen_hit) begin
					state_nx = vpdt_pkg::BK_EMIT;
				end else if (!seen_last) begin
					state_nx = vpdt_pkg::BK_SEEN_RD;
				end else if (voter_fill_q == '0) begin
					state_nx = vpdt_pkg::BK_COMMIT;
				end else begin
					state_nx = vpdt_pkg::BK_VOT_RD;
				end
			end
			vpdt_pkg::BK_VOT_RD:   state_nx = vpdt_pkg::BK_VOT_CMP;
			vpdt_pkg::BK_VOT_CMP:  state_nx = (voter_hit || voter_last) ?
				vpdt_pkg::BK_COMMIT : vpdt_pkg::BK_VOT_RD;
			vpdt_pkg::BK_COMMIT:   state_nx = vpdt_pkg::BK_EMIT;
			vpdt_pkg::BK_DIV_LOAD: state_nx = vpdt_pkg::BK_DIV;
			vpdt_pkg::BK_DIV: begin
				if (bit_q == '0) begin
					state_nx = (idx_q == vpdt_pkg::OPT_W'(NOPT - 1)) ?
						vpdt_pkg::BK_ROUND : vpdt_pkg::BK_DIV_LOAD;
				end
			end
			vpdt_pkg::BK_ROUND: begin
				if (sum_q >= vpdt_pkg::PCT_FULL || !best_found) begin
					state_nx = vpdt_pkg::BK_EMIT;
				end
			end
			vpdt_pkg::BK_EMIT: begin
				if (!m_tvalid || m_tready) begin
					state_nx = vpdt_pkg::BK_IDLE;
				end
			end
			default: state_nx = vpdt_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			vpdt_pkg::BK_IDLE:    ctl.pop = !q_empty;
			vpdt_pkg::BK_SEEN_RD: ctl.seen_re = 1'b1;
			vpdt_pkg::BK_VOT_RD:  ctl.voter_re = 1'b1;
			vpdt_pkg::BK_EMIT:    ctl.emit = !m_tvalid || m_tready;
			default:              ctl = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.seen_re) begin
			seen_rd_q <= seen_mem[k_q[vpdt_pkg::SEEN_AW-1:0]];
		end
		if (ctl.voter_re) begin
			voter_rd_q <= voter_mem[k_q[vpdt_pkg::VOTER_AW-1:0]];
		end
		if (state_q == vpdt_pkg::BK_COMMIT && !full_hit) begin
			seen_mem[seen_fill_q[vpdt_pkg::SEEN_AW-1:0]] <= {req_q.seq, req_q.opt, req_q.id};
			voter_mem[found_q ? vi_q : voter_fill_q[vpdt_pkg::VOTER_AW-1:0]] <=
				{req_q.opt, req_q.id};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			req_q <= head;
		end
		case (state_q)
			vpdt_pkg::BK_VOT_CMP: begin
				if (voter_hit) begin
					old_opt_q <= voter_rd_q[VOTER_W-1:vpdt_pkg::ID_W];
					vi_q      <= k_q[vpdt_pkg::VOTER_AW-1:0];
				end
			end
			vpdt_pkg::BK_DIV_LOAD: begin
				divd_q <= vpdt_pkg::DIVD_W'(cnt_sel) * vpdt_pkg::DIVD_W'(100);
				drem_q <= '0;
			end
			vpdt_pkg::BK_DIV: begin
				divd_q <= divd_nx;
				drem_q <= rem_nx;
				if (bit_q == '0) begin
					pct_q[idx_q] <= divd_nx[vpdt_pkg::PCT_W-1:0];
					rem_q[idx_q] <= rem_nx;
				end
			end
			vpdt_pkg::BK_ROUND: begin
				if (sum_q < vpdt_pkg::PCT_FULL && best_found) begin
					pct_q[best_idx] <= pct_q[best_idx] + 7'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vpdt_pkg::BK_IDLE;
			seen_fill_q  <= '0;
			voter_fill_q <= '0;
			k_q          <= '0;
			found_q      <= 1'b0;
			status_q     <= vpdt_pkg::ST_IGNORE;
			idx_q        <= '0;
			bit_q        <= '0;
			sum_q        <= '0;
			bumped_q     <= '0;
			m_tvalid     <= 1'b0;
			for (int i = 0; i < NOPT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;
			case (state_q)
				vpdt_pkg::BK_IDLE: begin
					k_q      <= '0;
					found_q  <= 1'b0;
					idx_q    <= '0;
					sum_q    <= '0;
					bumped_q <= '0;
					status_q <= (head.kind == vpdt_pkg::KIND_REPORT) ?
						vpdt_pkg::ST_REPORT : vpdt_pkg::ST_IGNORE;
					if (ctl.pop && head.kind == vpdt_pkg::KIND_CLEAR) begin
						seen_fill_q  <= '0;
						voter_fill_q <= '0;
						for (int i = 0; i < NOPT; i++) begin
							cnt_q[i] <= '0;
						end
					end
				end
				vpdt_pkg::BK_SEEN_CMP: begin
					k_q <= seen_last ? '0 : k_inc;
					if (seen_hit) begin
						status_q <= vpdt_pkg::ST_DUP;
					end
				end
				vpdt_pkg::BK_VOT_CMP: begin
					k_q <= k_inc;
					if (voter_hit) begin
						found_q <= 1'b1;
					end
				end
				vpdt_pkg::BK_COMMIT: begin
					if (full_hit) begin
						status_q <= vpdt_pkg::ST_FULL;
					end else begin
						status_q    <= vpdt_pkg::ST_NEW;
						seen_fill_q <= seen_fill_q + FW'(1);
						if (!found_q) begin
							voter_fill_q <= voter_fill_q + FW'(1);
						end
						for (int i = 0; i < NOPT; i++) begin
							cnt_q[i] <= cnt_q[i]
								- FW'(found_q && old_opt_q == vpdt_pkg::OPT_W'(i) && cnt_q[i] != '0)
								+ FW'(req_q.opt == vpdt_pkg::OPT_W'(i));
						end
					end
				end
				vpdt_pkg::BK_DIV_LOAD: bit_q <= 5'(vpdt_pkg::DIVD_W - 1);
				vpdt_pkg::BK_DIV: begin
					bit_q <= bit_q - 5'd1;
					if (bit_q == '0) begin
						idx_q <= idx_q + vpdt_pkg::OPT_W'(1);
						sum_q <= sum_q + divd_nx[vpdt_pkg::PCT_W-1:0];
					end
				end
				vpdt_pkg::BK_ROUND: begin
					if (sum_q < vpdt_pkg::PCT_FULL && best_found) begin
						bumped_q[best_idx] <= 1'b1;
						sum_q <= sum_q + 7'd1;
					end
				end
				default: begin
				end
			endcase
			if (ctl.emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			m_tuser <= status_q;
			m_tdata <= '0;
			m_tdata[80:70] <= voter_fill_q;
			if (status_q == vpdt_pkg::ST_REPORT) begin
				if (voter_fill_q != '0) begin
					for (int i = 0; i < NOPT && i < 5; i++) begin
						m_tdata[35 + 7*i +: 7] <= pct_q[i];
					end
				end
			end else if (status_q != vpdt_pkg::ST_IGNORE) begin
				m_tdata[31:0]  <= req_q.id;
				m_tdata[34:32] <= req_q.opt;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/vote_packet_dedup_tally.sv
// Top level of the voting-remote record dedup and tally block.
`timescale 1ns / 1ps
`default_nettype none
// Each request is one command: a response record, a report or a clear. The front end
// checks and decodes a record in the cycle it is accepted and places it in a two-entry
// queue; the back end then works on one request at a time. A record searches the seen
// table one entry at a time, with a read state and a compare state per entry, and, when
// new, the voter table the same way, since each table has a single read port.
// A report with voters runs five 17-step divisions and up to five rounding steps.
// A clear gives no result. Tables need no clearing after reset.
module vote_packet_dedup_tally (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// head_first, head_second, answer_code, id_high, id_mid, id_low, sequence_byte
	input  wire logic [55:0] s_tdata,
	// cmd
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// voter_id, choice, pct_a, pct_b, pct_c, pct_d, pct_e, voters_total, zero pad
	output logic [87:0]      m_tdata,
	// status
	output logic [2:0]       m_tuser
);

	vpdt_pkg::req_t push_req, head;
	logic push, pop, q_full, q_empty;

	vpdt_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.req      (push_req)
	);

	vpdt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	vpdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("request queue overflow");

	a_report_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == vpdt_pkg::ST_REPORT && m_tdata[80:70] != '0) |->
		(8'(m_tdata[41:35]) + 8'(m_tdata[48:42]) + 8'(m_tdata[55:49]) +
		 8'(m_tdata[62:56]) + 8'(m_tdata[69:63]) == 8'd100))
		else $error("report percentages do not sum to 100");

	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == vpdt_pkg::ST_IGNORE) |-> (m_tdata[34:0] == '0))
		else $error("ignored record carries an id or option");

endmodule
`default_nettype wire
